/* hw/rtl/mcam_pkg.sv */
`default_nettype none

package mcam_pkg;

    localparam int NUM_AXES       = 6;
    localparam int NUM_STICK_AXES = 4;

    localparam int BYTE_W      = 8;
    localparam int CHAN_NIB_W  = 4;
    localparam int CHANNEL_W   = 5;
    localparam int AXIS_IDX_W  = 3;
    localparam int AXIS_VAL_W  = 16;
    localparam int OUT_DATA_W  = 40;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_FILTER  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTROLLER_BASE = 1'd1;

    localparam logic [CHANNEL_W-1:0] FILTER_RESET = 5'd0;
    localparam logic [BYTE_W-1:0]    BASE_RESET   = 8'd40;

    localparam logic [3:0] STATUS_CC_NIB = 4'hB;

    localparam int STICK_CENTER = 64;
    localparam int FULL_SCALE   = 32767;
    localparam int STICK_SPAN   = 63;
    localparam int TRIG_SPAN    = 127;
    localparam int SAT_MAX      = 32767;
    localparam int SAT_MIN      = -32768;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_CTRL  = 3'b010,
        PH_VALUE = 3'b100
    } phase_t;

    typedef struct packed {
        logic                  valid;
        logic [CHAN_NIB_W-1:0] chan_nib;
        logic [BYTE_W-1:0]     controller;
        logic [BYTE_W-1:0]     level;
    } msg_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0]         channel;
        logic [BYTE_W-1:0]            controller;
        logic [BYTE_W-1:0]            level;
        logic                         axis_hit;
        logic [AXIS_IDX_W-1:0]        axis_num;
        logic signed [AXIS_VAL_W-1:0] axis_value;
    } result_t;

    typedef logic signed [AXIS_VAL_W-1:0] lut_t [0:255];

    function automatic logic signed [AXIS_VAL_W-1:0] sat16(int v);
        logic signed [AXIS_VAL_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = 16'sh7FFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = AXIS_VAL_W'(v);
        end
        return r;
    endfunction

    // Scaled axis value for every possible value byte, built at elaboration.
    function automatic lut_t build_lut(bit stick);
        lut_t t;
        int   v;
        for (int i = 0; i < 256; i++)
        begin
            if (stick)
            begin
                v = ((i - STICK_CENTER) * FULL_SCALE) / STICK_SPAN;
            end
            else
            begin
                v = (i * FULL_SCALE) / TRIG_SPAN;
            end
            t[i] = sat16(v);
        end
        return t;
    endfunction

    localparam lut_t STICK_LUT = build_lut(1'b1);
    localparam lut_t TRIG_LUT  = build_lut(1'b0);

endpackage

`default_nettype wire

/* hw/rtl/mcam_parser.sv */
`default_nettype none

module mcam_parser
    import mcam_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic              last_in,
    output msg_t                   msg
);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [CHAN_NIB_W-1:0] chan_reg;
    logic [CHAN_NIB_W-1:0] chan_next;
    logic [BYTE_W-1:0]     ctrl_reg;
    logic [BYTE_W-1:0]     ctrl_next;

    always_comb
    begin
        phase_next = phase_reg;
        chan_next  = chan_reg;
        ctrl_next  = ctrl_reg;
        msg.valid      = 1'b0;
        msg.chan_nib   = chan_reg;
        msg.controller = ctrl_reg;
        msg.level      = byte_in;
        if (step)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (byte_in[7:4] == STATUS_CC_NIB)
                    begin
                        chan_next  = byte_in[CHAN_NIB_W-1:0];
                        phase_next = PH_CTRL;
                    end
                end
                PH_CTRL:
                begin
                    ctrl_next  = byte_in;
                    phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    msg.valid  = 1'b1;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            // The end of a packet drops any partial message.
            if (last_in)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            chan_reg  <= '0;
            ctrl_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
            ctrl_reg  <= ctrl_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mcam_axis_map.sv */
`default_nettype none

module mcam_axis_map
    import mcam_pkg::*;
(
    input  wire msg_t                   msg,
    input  wire logic [CHANNEL_W-1:0]   channel_filter,
    input  wire logic [BYTE_W-1:0]      controller_base,
    output logic                        keep,
    output result_t                     result
);

    logic [CHANNEL_W-1:0] channel;
    logic [BYTE_W:0]      diff;
    logic                 in_range;
    logic                 is_stick;

    always_comb
    begin
        channel  = CHANNEL_W'({1'b0, msg.chan_nib}) + CHANNEL_W'(1);
        keep     = msg.valid && ((channel_filter == '0) || (channel_filter == channel));
        diff     = {1'b0, msg.controller} - {1'b0, controller_base};
        in_range = !diff[BYTE_W] && (diff < (BYTE_W+1)'(NUM_AXES));
        is_stick = diff < (BYTE_W+1)'(NUM_STICK_AXES);

        result.channel    = channel;
        result.controller = msg.controller;
        result.level      = msg.level;
        result.axis_hit   = in_range;
        result.axis_num   = '0;
        result.axis_value = '0;
        if (in_range)
        begin
            result.axis_num   = diff[AXIS_IDX_W-1:0];
            result.axis_value = is_stick ? STICK_LUT[msg.level] : TRIG_LUT[msg.level];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/midi_cc_axis_mapper.sv */
// An accepted word is first registered in the input stage; its result word is then registered
// in the result stage and shown on the output, once the result stage is free.
// Throughput: one input word per cycle; ready drops only while the result is stalled.
// Bytes that complete no kept control-change message give no result word.
// Reset (rst_n low, asynchronous) empties both stages, returns the parser to idle,
// and sets channel_filter to 0 and controller_base to 40.
`default_nettype none

module midi_cc_axis_mapper
    import mcam_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // in_byte
    input  wire logic                  s_axis_tlast,   // packet_end
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // channel, controller, level, axis number, axis_value
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tuser,   // axis_hit
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [CHANNEL_W-1:0] filter_reg;
    logic [BYTE_W-1:0]    base_reg;

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    logic                 advance;
    logic                 step;
    logic                 keep;
    msg_t                 msg;
    result_t              result;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= FILTER_RESET;
            base_reg   <= BASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CHANNEL_FILTER:  filter_reg <= cfg_wdata[CHANNEL_W-1:0];
                REG_CONTROLLER_BASE: base_reg   <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    mcam_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .msg     (msg)
    );

    mcam_axis_map u_axis_map (
        .msg             (msg),
        .channel_filter  (filter_reg),
        .controller_base (base_reg),
        .keep            (keep),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && keep)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.axis_hit;
    assign m_axis_tdata  = {out_reg.axis_value, out_reg.axis_num, out_reg.level,
                            out_reg.controller, out_reg.channel};

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("Input word lost while the result stage was stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.axis_hit |->
            (out_reg.axis_num == '0) && (out_reg.axis_value == '0))
        else $error("Axis fields nonzero on a result without an axis hit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.channel != '0))
        else $error("Result carries channel zero.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.axis_hit |->
            ({1'b0, out_reg.axis_num} < (AXIS_IDX_W+1)'(NUM_AXES)))
        else $error("Axis index beyond the number of axes.");

    assert property (@(posedge clk) disable iff (!rst_n)
        keep |-> step)
        else $error("Result produced without a word moving out of the input stage.");

endmodule

`default_nettype wire

/* bench/cc_result_checker.sv */
`timescale 1ns / 1ps

module cc_result_checker
    import mcam_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         fails,
    output int                         pending,
    output int                         results_seen,
    output int                         hits_seen
);

    localparam int CTRL_LSB  = CHANNEL_W;
    localparam int LEVEL_LSB = CTRL_LSB + BYTE_W;
    localparam int INDEX_LSB = LEVEL_LSB + BYTE_W;
    localparam int VALUE_LSB = INDEX_LSB + AXIS_IDX_W;

    phase_t                       parse_phase;
    logic [CHAN_NIB_W-1:0]        held_nib;
    logic [BYTE_W-1:0]            held_ctrl;
    logic [CHANNEL_W-1:0]         filter_q;
    logic [BYTE_W-1:0]            base_q;
    logic signed [AXIS_VAL_W-1:0] axis_mirror [NUM_AXES];
    result_t                      expected_cc [$];

    initial
    begin
        fails = 0;
        pending = 0;
        results_seen = 0;
        hits_seen = 0;
    end

    function automatic logic signed [AXIS_VAL_W-1:0] scale_level(bit stick,
                                                                 logic [BYTE_W-1:0] lvl);
        int raw;
        if (stick)
        begin
            raw = ((int'(lvl) - STICK_CENTER) * FULL_SCALE) / STICK_SPAN;
        end
        else
        begin
            raw = (int'(lvl) * FULL_SCALE) / TRIG_SPAN;
        end
        if (raw > SAT_MAX)
        begin
            raw = SAT_MAX;
        end
        else if (raw < SAT_MIN)
        begin
            raw = SAT_MIN;
        end
        return raw[AXIS_VAL_W-1:0];
    endfunction

    task automatic report(string field, int got, int want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, field, got, want);
        fails++;
    endtask

    task automatic parse_midi_byte(logic [BYTE_W-1:0] b, logic last);
        result_t               res;
        logic [CHANNEL_W-1:0]  ch;
        int                    idx;
        case (parse_phase)
            PH_IDLE:
            begin
                if (b[7:4] == STATUS_CC_NIB)
                begin
                    held_nib = b[3:0];
                    parse_phase = PH_CTRL;
                end
            end
            PH_CTRL:
            begin
                held_ctrl = b;
                parse_phase = PH_VALUE;
            end
            default:
            begin
                parse_phase = PH_IDLE;
                ch = {1'b0, held_nib} + 5'd1;
                if (filter_q == '0 || filter_q == ch)
                begin
                    res = '0;
                    res.channel = ch;
                    res.controller = held_ctrl;
                    res.level = b;
                    idx = int'(held_ctrl) - int'(base_q);
                    if (idx >= 0 && idx < NUM_AXES)
                    begin
                        res.axis_hit = 1'b1;
                        res.axis_num = idx[AXIS_IDX_W-1:0];
                        res.axis_value = scale_level(idx < NUM_STICK_AXES, b);
                        axis_mirror[idx] = res.axis_value;
                    end
                    expected_cc.push_back(res);
                end
            end
        endcase
        if (last)
        begin
            parse_phase = PH_IDLE;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_cc.size() == 0)
        begin
            report("result count", results_seen + 1, results_seen);
            return;
        end
        want = expected_cc.pop_front();
        results_seen++;
        if (m_axis_tuser)
        begin
            hits_seen++;
        end
        if (m_axis_tdata[CHANNEL_W-1:0] != want.channel)
        begin
            report("channel", int'(m_axis_tdata[CHANNEL_W-1:0]), int'(want.channel));
        end
        if (m_axis_tdata[CTRL_LSB +: BYTE_W] != want.controller)
        begin
            report("controller", int'(m_axis_tdata[CTRL_LSB +: BYTE_W]),
                   int'(want.controller));
        end
        if (m_axis_tdata[LEVEL_LSB +: BYTE_W] != want.level)
        begin
            report("level", int'(m_axis_tdata[LEVEL_LSB +: BYTE_W]), int'(want.level));
        end
        if (m_axis_tuser != want.axis_hit)
        begin
            report("axis_hit", int'(m_axis_tuser), int'(want.axis_hit));
        end
        if (m_axis_tdata[INDEX_LSB +: AXIS_IDX_W] != want.axis_num)
        begin
            report("axis number", int'(m_axis_tdata[INDEX_LSB +: AXIS_IDX_W]),
                   int'(want.axis_num));
        end
        if (m_axis_tdata[VALUE_LSB +: AXIS_VAL_W] != want.axis_value)
        begin
            report("axis_value", int'($signed(m_axis_tdata[VALUE_LSB +: AXIS_VAL_W])),
                   int'(want.axis_value));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase = PH_IDLE;
            held_nib = '0;
            held_ctrl = '0;
            filter_q = FILTER_RESET;
            base_q = BASE_RESET;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                axis_mirror[i] = '0;
            end
            expected_cc.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_CHANNEL_FILTER)
                begin
                    filter_q = cfg_wdata[CHANNEL_W-1:0];
                end
                else if (cfg_addr == REG_CONTROLLER_BASE)
                begin
                    base_q = cfg_wdata;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_midi_byte(s_axis_tdata, s_axis_tlast);
            end
            pending <= expected_cc.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import mcam_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fails;
    int pending;
    int results_seen;
    int hits_seen;

    int words_sent = 0;
    int burst_left = 0;
    bit calm = 1'b0;
    int sink_mode = 0;
    int sink_timer = 0;
    int stall_left = 0;
    int filter_now = int'(FILTER_RESET);
    int base_now = int'(BASE_RESET);
    int n_start;

    always #1 clk = ~clk;

    midi_cc_axis_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    cc_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fails         (fails),
        .pending       (pending),
        .results_seen  (results_seen),
        .hits_seen     (hits_seen)
    );

    // The sink switches between always ready, short stalls and long stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (sink_timer == 0)
            begin
                sink_mode = $urandom_range(0, 2);
                sink_timer = $urandom_range(50, 400);
            end
            else
            begin
                sink_timer--;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_mode == 1 && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end
            else if (sink_mode == 2 && $urandom_range(0, 1) == 0)
            begin
                stall_left = $urandom_range(0, 19);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(logic [BYTE_W-1:0] b, logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle(int tail);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (tail) @(posedge clk);
    endtask

    task automatic apply_setting(int filt, int base);
        cfg_we <= 1'b1;
        cfg_addr <= REG_CHANNEL_FILTER;
        cfg_wdata <= filt[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_addr <= REG_CONTROLLER_BASE;
        cfg_wdata <= base[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        filter_now = filt;
        base_now = base;
    endtask

    function automatic logic [BYTE_W-1:0] pick_controller();
        int k;
        k = $urandom_range(0, 5);
        if ($urandom_range(0, 2) != 0 && base_now + k <= 255)
        begin
            return BYTE_W'(base_now + k);
        end
        else if ($urandom_range(0, 1) == 0 && base_now + 6 <= 255)
        begin
            return BYTE_W'(base_now + 6);
        end
        else if ($urandom_range(0, 1) == 0 && base_now > 0)
        begin
            return BYTE_W'(base_now - 1);
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd127;
            2: return BYTE_W'(63 + $urandom_range(0, 2));
            3, 4: return BYTE_W'($urandom_range(0, 255));
            default: return BYTE_W'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic send_packet();
        logic [CHAN_NIB_W-1:0] nib;
        int                    msgs;
        int                    n;
        case ($urandom_range(0, 9))
            0:
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    send_word(BYTE_W'($urandom_range(0, 255)),
                              i == n - 1 ? 1'($urandom_range(0, 1)) : 1'b0);
                end
            end
            1:
            begin
                send_word({STATUS_CC_NIB, 4'($urandom_range(0, 15))}, 1'b0);
                if ($urandom_range(0, 1) == 0)
                begin
                    send_word(pick_controller(), 1'b1);
                end
                else
                begin
                    send_word(BYTE_W'($urandom_range(0, 255)), 1'b0);
                    send_word(BYTE_W'($urandom_range(0, 255)), 1'b1);
                    send_word({STATUS_CC_NIB, 4'($urandom_range(0, 15))}, 1'b1);
                end
            end
            default:
            begin
                msgs = $urandom_range(1, 3);
                for (int m = 0; m < msgs; m++)
                begin
                    if (filter_now >= 1 && filter_now <= 16 && $urandom_range(0, 3) != 0)
                    begin
                        nib = 4'(filter_now - 1);
                    end
                    else
                    begin
                        nib = 4'($urandom_range(0, 15));
                    end
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_word(BYTE_W'($urandom_range(0, 175)), 1'b0);
                    end
                    send_word({STATUS_CC_NIB, nib}, 1'b0);
                    send_word(pick_controller(), 1'b0);
                    send_word(pick_level(), m == msgs - 1);
                end
            end
        endcase
    endtask

    logic [BYTE_W:0] directed [] = '{
        9'h090, 9'h045,
        9'h0B0, 9'd40, 9'h000,
        9'h0BF, 9'd43, 9'h07F,
        9'h0B3, 9'd44, 9'h0FF,
        9'h0B3, 9'd45, 9'h000,
        9'h0B5, 9'h0B7, 9'h080,
        9'h0B1, 9'h100 | 9'd41,
        9'h1B2,
        9'h0B4, 9'd39, 9'h140,
        9'h0B9, 9'd42, 9'h1FF
    };

    int filt_plan [8] = '{0, 16, 1, 17, 31, 7, 0, 12};
    int base_plan [8] = '{0, 255, 250, 40, 128, 0, 100, 37};

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1'b1;
        foreach (directed[i])
        begin
            send_word(directed[i][BYTE_W-1:0], directed[i][BYTE_W]);
        end
        calm = 1'b0;

        for (int p = 0; p < 8; p++)
        begin
            wait_idle(4);
            if (p >= 6)
            begin
                apply_setting($urandom_range(0, 16), $urandom_range(0, 255));
            end
            else
            begin
                apply_setting(filt_plan[p], base_plan[p]);
            end
            calm = (p % 3 == 2);
            n_start = words_sent;
            while (words_sent - n_start < 160)
            begin
                send_packet();
            end
        end

        wait_idle(10);
        $display("Sent %0d words under 9 register settings (all-pass, reject-all, one channel).",
                 words_sent);
        $display("Checked %0d result words, %0d of them with an axis update.",
                 results_seen, hits_seen);
        if (fails == 0 && pending == 0)
        begin
            $display("** midi_cc_axis_mapper: PASSED **");
        end
        else
        begin
            $display("** midi_cc_axis_mapper: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Timeout with %0d results still outstanding.", pending);
        $display("** midi_cc_axis_mapper: FAILED **");
        $finish;
    end

endmodule
